@@ rtl/slc_pkg.sv @@
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types, constants and helpers of the source line classifier.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int unsigned LineMaxDef    = 512;
  localparam int unsigned PatternMaxDef = 4;
  localparam int unsigned CountBitsDef  = 24;
  localparam int unsigned PatBytes      = 4;
  localparam int unsigned TextW         = 32;
  localparam int unsigned LenW          = 3;
  localparam int unsigned OutCntW       = 24;
  localparam int unsigned CfgIdxW       = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegStartText = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStartLen  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegEndText   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegEndLen    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPpText    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPpLen     = 3'd5;

  // line classes
  localparam logic [1:0] ClsBlank   = 2'd0;
  localparam logic [1:0] ClsComment = 2'd1;
  localparam logic [1:0] ClsPreproc = 2'd2;
  localparam logic [1:0] ClsCode    = 2'd3;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNl    = 8'h0a;

  typedef struct packed {
    logic [TextW-1:0] text;
    logic [2:0]       len;
  } pat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // effective pattern length: clamp then stop at first zero byte
  function automatic logic [2:0] pat_len(input pat_t p, input int unsigned pmax);
    logic [2:0] n;
    logic       stop;
    n    = (pmax < 32'(p.len)) ? 3'(pmax) : p.len;
    if (n > 3'(PatBytes)) n = 3'(PatBytes);
    stop = 1'b0;
    pat_len = 3'd0;
    for (int i = 0; i < PatBytes; i++) begin
      if (!stop && 3'(i) < n) begin
        if (p.text[8*i +: 8] == 8'd0) stop = 1'b1;
        else pat_len = 3'(i + 1);
      end
    end
  endfunction

endpackage

@@ rtl/slc_scan.sv @@
// ----------------------------------------------------------------------------
// slc_scan
// Sequencer for one line: length scan, blank check, comment blanking and
// class decision, one stored byte per cycle through a window of 4 bytes.
// ----------------------------------------------------------------------------
module slc_scan #(
  parameter int unsigned LineMax    = slc_pkg::LineMaxDef,
  parameter int unsigned PatternMax = slc_pkg::PatternMaxDef,
  localparam int unsigned AW = $clog2(LineMax)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [AW-1:0]        len_i,
  input  logic                 in_comment_i,
  input  slc_pkg::pat_t        pat_s_i,
  input  slc_pkg::pat_t        pat_e_i,
  input  slc_pkg::pat_t        pat_p_i,
  output logic [AW-1:0]        rd_addr_o,
  input  logic [7:0]           rd_data_i,
  output logic                 done_o,
  output logic [1:0]           cls_o,
  output logic                 inl_o,
  output logic                 in_comment_o
);
  import slc_pkg::*;

  typedef enum logic [5:0] {
    SIdle  = 6'b000001,
    SSig   = 6'b000010,
    SFill  = 6'b000100,
    SBlank = 6'b001000,
    SPass  = 6'b010000,
    SDone  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] ptr_q, ptr_d, sig_q, sig_d, s_q, s_d;
  logic [AW-1:0] rdp;
  logic          rdv_q;
  // window: bytes s..s+3 after blanking
  logic [7:0]    win_q [PatBytes];
  logic [7:0]    win_d [PatBytes];
  logic [2:0]    wfill_q, wfill_d;
  logic          inc_q, inc_d, has_q, has_d, ns_q, ns_d;
  logic          pp_q, pp_d;
  logic [1:0]    cls_q, cls_d;
  logic          inl_q, inl_d;
  logic [2:0]    ns, ne, np;

  assign ns = pat_len(pat_s_i, PatternMax);
  assign ne = pat_len(pat_e_i, PatternMax);
  assign np = pat_len(pat_p_i, PatternMax);

  assign rd_addr_o    = rdp;
  assign done_o       = (state_q == SDone);
  assign cls_o        = cls_q;
  assign inl_o        = inl_q;
  assign in_comment_o = inc_q;

  // match helper over the window (positions beyond sig read zero)
  function automatic logic win_match(input logic [7:0] w [PatBytes],
                                     input logic [TextW-1:0] t, input logic [2:0] n);
    logic m;
    m = (n != 3'd0);
    for (int k = 0; k < PatBytes; k++)
      if (3'(k) < n && w[k] != t[8*k +: 8]) m = 1'b0;
    return m;
  endfunction

  // sequencer
  always_comb begin
    logic [7:0] w [PatBytes];
    state_d = state_q; ptr_d = ptr_q; sig_d = sig_q; s_d = s_q;
    win_d = win_q; wfill_d = wfill_q; inc_d = inc_q; has_d = has_q;
    ns_d = ns_q; pp_d = pp_q; cls_d = cls_q; inl_d = inl_q;
    rdp = ptr_q;
    w = win_q;
    unique case (state_q)
      SIdle: begin
        rdp = '0;
        if (start_i) begin
          state_d = SSig; ptr_d = '0; sig_d = '0; inc_d = in_comment_i;
          ns_d = 1'b1;
        end
      end
      // find first zero byte; ptr holds the address behind the read data
      SSig: begin
        rdp = sig_q;
        if (sig_q == len_i) begin
          state_d = SBlank; ptr_d = '0;
        end else if (ptr_q == sig_q) begin
          if (rd_data_i == 8'd0) begin
            state_d = SBlank; ptr_d = '0;
          end else begin
            if (!is_space(rd_data_i)) ns_d = 1'b0;
            sig_d = sig_q + 1'b1;
            rdp = sig_q + 1'b1;
          end
        end
        if (state_d == SSig) ptr_d = sig_d;
      end
      SBlank: begin
        if (ns_q) begin
          cls_d = ClsBlank; inl_d = 1'b0; inc_d = in_comment_i; state_d = SDone;
        end else begin
          has_d = inc_q; s_d = '0; ptr_d = '0; wfill_d = '0;
          for (int k = 0; k < PatBytes; k++) win_d[k] = 8'd0;
          ns_d = 1'b1; pp_d = (np != 3'd0); state_d = SFill;
        end
      end
      // preload window with first bytes of the line
      SFill: begin
        rdp = ptr_q;
        if (rdv_q && ptr_q != '0) begin
          win_d[wfill_q[1:0]] = (ptr_q - 1'b1 < sig_q) ? rd_data_i : 8'd0;
          wfill_d = wfill_q + 3'd1;
        end
        if (wfill_d == 3'(PatBytes)) begin
          state_d = SPass;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      // one scan position per cycle
      SPass: begin
        rdp = ptr_q + 1'b1;
        if (inc_q) begin
          if (win_match(w, pat_e_i.text, ne)) begin
            inc_d = 1'b0;
            for (int k = 0; k < PatBytes; k++) if (3'(k) < ne) w[k] = ChSpace;
          end else w[0] = ChSpace;
        end else if (win_match(w, pat_s_i.text, ns)) begin
          inc_d = 1'b1; has_d = 1'b1;
          for (int k = 0; k < PatBytes; k++) if (3'(k) < ns) w[k] = ChSpace;
        end
        // prefix check on bytes that leave the window in final form
        if (s_q < AW'(np) && w[0] != pat_p_i.text[8*s_q[1:0] +: 8]) pp_d = 1'b0;
        if (s_q < sig_q && !is_space(w[0])) ns_d = 1'b0;
        for (int k = 0; k < PatBytes-1; k++) win_d[k] = w[k+1];
        win_d[PatBytes-1] = (ptr_q < sig_q) ? rd_data_i : 8'd0;
        s_d = s_q + 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (s_q + 1'b1 >= sig_q) begin
          if (ne == 3'd0) inc_d = 1'b0;
          if (sig_q < AW'(np)) pp_d = 1'b0;
          if (pp_d) begin cls_d = ClsPreproc; inl_d = has_d; end
          else if (ns_d) begin cls_d = ClsComment; inl_d = 1'b0; end
          else begin cls_d = ClsCode; inl_d = has_d; end
          state_d = SDone;
        end
      end
      SDone:   state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      rdv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rdv_q   <= (state_d == SFill) || (state_d == SPass) || (state_d == SSig);
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d; sig_q <= sig_d; s_q <= s_d; win_q <= win_d;
    wfill_q <= wfill_d; inc_q <= inc_d; has_q <= has_d; ns_q <= ns_d;
    pp_q <= pp_d; cls_q <= cls_d; inl_q <= inl_d;
  end

endmodule

@@ rtl/source_line_classifier.sv @@
// ----------------------------------------------------------------------------
// source_line_classifier
// Gathers text bytes into lines and classifies each completed line.
// ----------------------------------------------------------------------------
// timing: a line's result follows its scan, which reads the line store through its
//   single read port: a length scan, then for a non-blank line a window fill and a
//   scan pass; an empty end of file goes straight to its result beat
// throughput: one beat at a time; s_axis_tready is low from a line-ending beat
//   until its result beat is taken
// reset: control state, comment state, line length and counters clear at once;
//   the line store holds no reset value and needs no clearing pass
module source_line_classifier #(
  parameter int unsigned LineMax    = slc_pkg::LineMaxDef,
  parameter int unsigned PatternMax = slc_pkg::PatternMaxDef,
  parameter int unsigned CountBits  = slc_pkg::CountBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [slc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [slc_pkg::TextW-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // char_code
  input  logic                          s_axis_tuser,  // op
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // line_valid, line_class, inline_comment, file_done, total, blank,
  // comment, inline, preproc, code counts (24 each), zero pad to 152
  output logic [151:0]                  m_axis_tdata
);
  import slc_pkg::*;

  localparam int unsigned AW = $clog2(LineMax);
  localparam logic [CountBits-1:0] CntMax = '1;

  typedef enum logic [3:0] {
    TIdle = 4'b0001,
    TScan = 4'b0010,
    TWait = 4'b0100,
    TOut  = 4'b1000
  } top_e;

  top_e          st_q, st_d;
  pat_t          ps_q, pe_q, pp_q;
  logic [7:0]    mem [LineMax-1];
  logic [7:0]    rd_q;
  logic [AW-1:0] len_q, rd_addr;
  logic          inc_q, eof_q;
  logic [CountBits-1:0] cnt_q [6];
  logic [151:0]  out_q;
  logic          sc_start, sc_done, sc_inl, sc_inc;
  logic [1:0]    sc_cls;
  logic          acc;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == TIdle);
  assign m_axis_tvalid = (st_q == TOut);
  assign m_axis_tdata  = out_q;
  assign sc_start = (st_q == TScan);

  slc_scan #(.LineMax(LineMax), .PatternMax(PatternMax)) u_scan (
    .clk_i, .rst_ni, .start_i(sc_start), .len_i(len_q), .in_comment_i(inc_q),
    .pat_s_i(ps_q), .pat_e_i(pe_q), .pat_p_i(pp_q), .rd_addr_o(rd_addr),
    .rd_data_i(rd_q), .done_o(sc_done), .cls_o(sc_cls), .inl_o(sc_inl),
    .in_comment_o(sc_inc)
  );

  // line store
  always_ff @(posedge clk_i) begin
    if (acc && !s_axis_tuser && len_q < AW'(LineMax-1)) mem[len_q] <= s_axis_tdata;
    rd_q <= mem[rd_addr];
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      TIdle: if (acc) begin
        if (s_axis_tuser) st_d = (len_q != '0) ? TScan : TOut;
        else if (s_axis_tdata == ChNl || len_q + 1'b1 >= AW'(LineMax-1)) st_d = TScan;
      end
      TScan: st_d = TWait;
      TWait: if (sc_done) st_d = TOut;
      TOut:  if (m_axis_tready) st_d = TIdle;
      default: st_d = TIdle;
    endcase
  end

  function automatic logic [CountBits-1:0] bump(input logic [CountBits-1:0] c,
                                                input logic en);
    return (en && c != CntMax) ? c + 1'b1 : c;
  endfunction

  function automatic logic [OutCntW-1:0] ow(input logic [CountBits-1:0] c);
    return OutCntW'({{32{1'b0}}, c});
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [CountBits-1:0] c [6];
    if (!rst_ni) begin
      st_q <= TIdle; len_q <= '0; inc_q <= 1'b0; eof_q <= 1'b0;
      ps_q <= '{text: 32'd10799, len: 3'd2};
      pe_q <= '{text: 32'd12074, len: 3'd2};
      pp_q <= '{text: 32'd35, len: 3'd1};
      for (int i = 0; i < 6; i++) cnt_q[i] <= '0;
      out_q <= '0;
    end else begin
      st_q <= st_d;
      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegStartText: ps_q.text <= cfg_wdata_i;
          RegStartLen:  ps_q.len  <= cfg_wdata_i[2:0];
          RegEndText:   pe_q.text <= cfg_wdata_i;
          RegEndLen:    pe_q.len  <= cfg_wdata_i[2:0];
          RegPpText:    pp_q.text <= cfg_wdata_i;
          RegPpLen:     pp_q.len  <= cfg_wdata_i[2:0];
          default: ;
        endcase
      end
      // input beat
      if (acc) begin
        eof_q <= s_axis_tuser;
        if (!s_axis_tuser && len_q < AW'(LineMax-1)) len_q <= len_q + 1'b1;
        if (s_axis_tuser && len_q == '0) begin
          out_q <= {3'd0, ow(cnt_q[5]), ow(cnt_q[4]), ow(cnt_q[3]), ow(cnt_q[2]),
                    ow(cnt_q[1]), ow(cnt_q[0]), 1'b1, 1'b0, ClsBlank, 1'b0};
          for (int i = 0; i < 6; i++) cnt_q[i] <= '0;
          inc_q <= 1'b0;
        end
      end
      // line result
      if (st_q == TWait && sc_done) begin
        c[0] = bump(cnt_q[0], 1'b1);
        c[1] = bump(cnt_q[1], sc_cls == ClsBlank);
        c[2] = bump(cnt_q[2], sc_cls == ClsComment);
        c[3] = bump(cnt_q[3], sc_inl);
        c[4] = bump(cnt_q[4], sc_cls == ClsPreproc);
        c[5] = bump(cnt_q[5], sc_cls == ClsCode);
        out_q <= {3'd0, ow(c[5]), ow(c[4]), ow(c[3]), ow(c[2]), ow(c[1]), ow(c[0]),
                  eof_q, sc_inl, sc_cls, 1'b1};
        len_q <= '0;
        if (eof_q) begin
          for (int i = 0; i < 6; i++) cnt_q[i] <= '0;
          inc_q <= 1'b0;
        end else begin
          for (int i = 0; i < 6; i++) cnt_q[i] <= c[i];
          inc_q <= sc_inc;
        end
      end
    end
  end

endmodule
